/* rtl/core/a2p_pkg.sv */
// a2p_pkg: shared constants, types and coefficient table of the atan2 block.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package a2p_pkg;

    // Coordinate and angle formats
    localparam int COORD_W   = 16;
    localparam int ANGLE_F   = 13;
    localparam int ANGLE_W   = 16;

    // Divider: one quotient bit per cell, quotient is floor(small * 2^17 / big)
    localparam int QUO_W     = 17;
    localparam int DIV_STEPS = QUO_W;

    // Ratio, square and Horner accumulator widths
    localparam int RATIO_W   = 16;
    localparam int SQ_W      = 16;
    localparam int ACC_W     = 19;
    localparam int POLY_W    = 17;
    localparam int HORNER_N  = 6;

    // Base angle and working angle widths
    localparam int BASE_W    = ANGLE_F + 2;
    localparam int WORK_W    = ANGLE_F + 5;

    // Pi with 60 fraction bits, rounded to the angle scale
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_Q64 =
        (PI_Q60 + (64'd1 << (59 - ANGLE_F))) >> (60 - ANGLE_F);
    localparam logic [63:0] HALF_PI_Q64 =
        (PI_Q60 + (64'd1 << (60 - ANGLE_F))) >> (61 - ANGLE_F);
    localparam logic [63:0] LIM_HI64 = (PI_Q64 < 64'd32767) ? PI_Q64 : 64'd32767;
    localparam logic [63:0] LIM_LO64 = (PI_Q64 < 64'd32768) ? PI_Q64 : 64'd32768;

    localparam logic signed [WORK_W-1:0] PI_Q      = WORK_W'(PI_Q64);
    localparam logic signed [WORK_W-1:0] HALF_PI_Q = WORK_W'(HALF_PI_Q64);
    localparam logic signed [WORK_W-1:0] LIM_HI    = WORK_W'(LIM_HI64);
    localparam logic signed [WORK_W-1:0] LIM_LO    = -WORK_W'(LIM_LO64);

    // Odd minimax polynomial coefficients, signed Q1.16, highest order first
    localparam logic signed [ACC_W-1:0] POLY_COEF [0:HORNER_N] = '{
        19'sd473, -19'sd2298, 19'sd5353, -19'sd8765,
        19'sd13013, -19'sd21840, 19'sd65536
    };

    // Per-item flags that ride along the pipeline
    typedef struct packed {
        logic zero;   // both coordinates zero
        logic eq;     // equal magnitudes
        logic ybig;   // |y| > |x|, octant reflection
        logic xneg;   // x < 0
        logic yneg;   // y < 0
    } t_side;

endpackage

`default_nettype wire

/* rtl/core/atan2_polynomial_approx.sv */
// atan2_polynomial_approx: top level, four-quadrant arctangent pipeline.
// Depends on a2p_pkg, a2p_div_cell, a2p_horner_cell.
//
// Usage:
//   Input channel i_valid/o_ready carries i_coord_x, i_coord_y (signed).
//   Output channel o_valid/i_ready carries o_angle (radians * 2^13, signed,
//   limited to +-pi) and o_both_zero (set, with angle zero, for a (0,0) input).
//   A transfer happens on a rising edge with valid and ready both high.
// Pipeline: 28 register stages lie between input transfer and output valid:
//   one input stage, 17 divider cells (one quotient bit each), ratio and
//   square stages, six Horner cells, a base-angle multiply stage and the
//   output register.
// Throughput: one item per cycle; every stage is a register with its own
//   valid bit, so a new item enters each cycle while the pipeline flows.
// Stall: when i_ready is low the output register holds; empty stages behind
//   it keep filling, and o_ready falls only once every stage holds an item.
// Reset: synchronous, active low; clears all valid bits, no items in flight.
`default_nettype none

module atan2_polynomial_approx
    import a2p_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [COORD_W-1:0] i_coord_x,
    input  wire logic signed [COORD_W-1:0] i_coord_y,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic signed [ANGLE_W-1:0]      o_angle,
    output logic                           o_both_zero
);

    // ---------------- input stage: magnitudes and octant ----------------
    logic [COORD_W-1:0] ax, ay, big, sml;
    t_side              in_side;
    logic               r_in_valid;
    logic [COORD_W-1:0] r_in_big, r_in_small;
    t_side              r_in_side;
    logic               in_adv;

    logic [DIV_STEPS:0] d_valid;
    logic [DIV_STEPS:0] d_ready;
    logic [COORD_W-1:0] d_rem  [0:DIV_STEPS];
    logic [COORD_W-1:0] d_big  [0:DIV_STEPS];
    logic [QUO_W-1:0]   d_quo  [0:DIV_STEPS];
    t_side              d_side [0:DIV_STEPS];

    always_comb begin
        ax = i_coord_x[COORD_W-1] ? (~i_coord_x + 1'b1) : i_coord_x;
        ay = i_coord_y[COORD_W-1] ? (~i_coord_y + 1'b1) : i_coord_y;
        in_side.ybig = (ay > ax);
        in_side.eq   = (ay == ax);
        in_side.xneg = i_coord_x[COORD_W-1];
        in_side.yneg = i_coord_y[COORD_W-1];
        big          = in_side.ybig ? ay : ax;
        sml          = in_side.ybig ? ax : ay;
        in_side.zero = (big == '0);
    end

    assign in_adv  = !r_in_valid || d_ready[0];
    assign o_ready = in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_valid) begin
            r_in_big   <= big;
            r_in_small <= sml;
            r_in_side  <= in_side;
        end
    end

    // ---------------- divider chain ----------------
    assign d_valid[0] = r_in_valid;
    assign d_rem[0]   = r_in_small;
    assign d_big[0]   = r_in_big;
    assign d_quo[0]   = '0;
    assign d_side[0]  = r_in_side;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        a2p_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d_valid[k]),
            .o_ready (d_ready[k]),
            .i_rem   (d_rem[k]),
            .i_big   (d_big[k]),
            .i_quo   (d_quo[k]),
            .i_side  (d_side[k]),
            .o_valid (d_valid[k+1]),
            .i_ready (d_ready[k+1]),
            .o_rem   (d_rem[k+1]),
            .o_big   (d_big[k+1]),
            .o_quo   (d_quo[k+1]),
            .o_side  (d_side[k+1])
        );
    end

    // ---------------- ratio stage: round half up, saturate ----------------
    logic [QUO_W:0]       qp1;
    logic [RATIO_W-1:0]   n_ratio;
    logic                 r_rt_valid;
    logic [RATIO_W-1:0]   r_rt_ratio;
    t_side                r_rt_side;
    logic                 rt_adv;
    logic                 sq_adv;

    always_comb begin
        qp1 = {1'b0, d_quo[DIV_STEPS]} + 1'b1;
        if (d_side[DIV_STEPS].eq || qp1[QUO_W]) begin
            n_ratio = '1;
        end else begin
            n_ratio = qp1[RATIO_W:1];
        end
    end

    assign rt_adv             = !r_rt_valid || sq_adv;
    assign d_ready[DIV_STEPS] = rt_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_valid <= 1'b0;
        end else if (rt_adv) begin
            r_rt_valid <= d_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rt_adv && d_valid[DIV_STEPS]) begin
            r_rt_ratio <= n_ratio;
            r_rt_side  <= d_side[DIV_STEPS];
        end
    end

    // ---------------- square stage ----------------
    logic [2*RATIO_W:0]   sq_full;
    logic                 r_sq_valid;
    logic [SQ_W-1:0]      r_sq;
    logic [RATIO_W-1:0]   r_sq_ratio;
    t_side                r_sq_side;

    logic [HORNER_N:0]       h_valid;
    logic [HORNER_N:0]       h_ready;
    logic signed [ACC_W-1:0] h_acc   [0:HORNER_N];
    logic [SQ_W-1:0]         h_sq    [0:HORNER_N];
    logic [RATIO_W-1:0]      h_ratio [0:HORNER_N];
    t_side                   h_side  [0:HORNER_N];

    assign sq_full = (2*RATIO_W+1)'(r_rt_ratio * r_rt_ratio) + (2*RATIO_W+1)'(32768);
    assign sq_adv  = !r_sq_valid || h_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
        end else if (sq_adv) begin
            r_sq_valid <= r_rt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sq_adv && r_rt_valid) begin
            r_sq       <= sq_full[SQ_W+15:16];
            r_sq_ratio <= r_rt_ratio;
            r_sq_side  <= r_rt_side;
        end
    end

    // ---------------- Horner chain ----------------
    assign h_valid[0] = r_sq_valid;
    assign h_acc[0]   = POLY_COEF[0];
    assign h_sq[0]    = r_sq;
    assign h_ratio[0] = r_sq_ratio;
    assign h_side[0]  = r_sq_side;

    for (genvar k = 0; k < HORNER_N; k++) begin : g_horner
        a2p_horner_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (h_valid[k]),
            .o_ready (h_ready[k]),
            .i_acc   (h_acc[k]),
            .i_sq    (h_sq[k]),
            .i_ratio (h_ratio[k]),
            .i_side  (h_side[k]),
            .i_coef  (POLY_COEF[k+1]),
            .o_valid (h_valid[k+1]),
            .i_ready (h_ready[k+1]),
            .o_acc   (h_acc[k+1]),
            .o_sq    (h_sq[k+1]),
            .o_ratio (h_ratio[k+1]),
            .o_side  (h_side[k+1])
        );
    end

    // ---------------- base angle: p * r, rounded to angle scale ----------------
    localparam int BPROD_W = POLY_W + RATIO_W + 1;

    logic [POLY_W-1:0]   poly_pos;
    logic [BPROD_W-1:0]  bprod;
    logic                r_bs_valid;
    logic [BASE_W-1:0]   r_bs_angle;
    t_side               r_bs_side;
    logic                bs_adv;
    logic                out_adv;

    always_comb begin
        poly_pos = h_acc[HORNER_N][ACC_W-1] ? '0 : h_acc[HORNER_N][POLY_W-1:0];
        bprod    = BPROD_W'(poly_pos * h_ratio[HORNER_N])
                 + (BPROD_W'(1) << (31 - ANGLE_F));
    end

    assign bs_adv            = !r_bs_valid || out_adv;
    assign h_ready[HORNER_N] = bs_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs_valid <= 1'b0;
        end else if (bs_adv) begin
            r_bs_valid <= h_valid[HORNER_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (bs_adv && h_valid[HORNER_N]) begin
            r_bs_angle <= bprod[32-ANGLE_F +: BASE_W];
            r_bs_side  <= h_side[HORNER_N];
        end
    end

    // ---------------- output stage: reflections and limits ----------------
    logic signed [WORK_W-1:0] a_base, a_oct, a_half, a_sgn, a_lim;
    logic                     r_out_valid;
    logic signed [ANGLE_W-1:0] r_out_angle;
    logic                     r_out_zero;

    always_comb begin
        a_base = WORK_W'(r_bs_angle);
        a_oct  = (r_bs_side.ybig && !r_bs_side.eq) ? (HALF_PI_Q - a_base) : a_base;
        a_half = r_bs_side.xneg ? (PI_Q - a_oct) : a_oct;
        a_sgn  = r_bs_side.yneg ? -a_half : a_half;
        priority if (r_bs_side.zero) begin
            a_lim = '0;
        end else if (a_sgn > LIM_HI) begin
            a_lim = LIM_HI;
        end else if (a_sgn < LIM_LO) begin
            a_lim = LIM_LO;
        end else begin
            a_lim = a_sgn;
        end
    end

    assign out_adv = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_bs_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_bs_valid) begin
            r_out_angle <= a_lim[ANGLE_W-1:0];
            r_out_zero  <= r_bs_side.zero;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_angle     = r_out_angle;
    assign o_both_zero = r_out_zero;

    // ---------------- assertions ----------------
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_both_zero) |-> (o_angle == '0))
        else $error("both_zero result with nonzero angle");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((WORK_W'(o_angle) <= LIM_HI) && (WORK_W'(o_angle) >= LIM_LO)))
        else $error("angle outside +-pi");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_ready)
        else $error("input stalled with empty first stage");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bs_valid && out_adv) |=> o_valid)
        else $error("base-angle item lost at output register");

endmodule

`default_nettype wire

/* rtl/core/a2p_div_cell.sv */
// a2p_div_cell: one restoring-division cell, produces one quotient bit.
// Depends on a2p_pkg.
`default_nettype none

module a2p_div_cell
    import a2p_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [COORD_W-1:0] i_rem,
    input  wire logic [COORD_W-1:0] i_big,
    input  wire logic [QUO_W-1:0]   i_quo,
    input  wire t_side              i_side,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [COORD_W-1:0]      o_rem,
    output logic [COORD_W-1:0]      o_big,
    output logic [QUO_W-1:0]        o_quo,
    output t_side                   o_side
);

    logic               r_valid;
    logic [COORD_W-1:0] r_rem;
    logic [COORD_W-1:0] r_big;
    logic [QUO_W-1:0]   r_quo;
    t_side              r_side;

    logic [COORD_W:0]   shifted;
    logic [COORD_W:0]   diff;
    logic               qbit;
    logic               adv;

    // Shift in a zero, trial subtract
    always_comb begin
        shifted = {i_rem, 1'b0};
        diff    = shifted - {1'b0, i_big};
        qbit    = (shifted >= {1'b0, i_big});
    end

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_rem  <= qbit ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
            r_big  <= i_big;
            r_quo  <= {i_quo[QUO_W-2:0], qbit};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_big   = r_big;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

`default_nettype wire

/* rtl/core/a2p_horner_cell.sv */
// a2p_horner_cell: one Horner step acc = rnd16(acc * s) + c.
// Depends on a2p_pkg.
`default_nettype none

module a2p_horner_cell
    import a2p_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic signed [ACC_W-1:0] i_acc,
    input  wire logic [SQ_W-1:0]         i_sq,
    input  wire logic [RATIO_W-1:0]      i_ratio,
    input  wire t_side                   i_side,
    input  wire logic signed [ACC_W-1:0] i_coef,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [ACC_W-1:0]      o_acc,
    output logic [SQ_W-1:0]              o_sq,
    output logic [RATIO_W-1:0]           o_ratio,
    output t_side                        o_side
);

    localparam int PROD_W = ACC_W + SQ_W + 1;

    logic                    r_valid;
    logic signed [ACC_W-1:0] r_acc;
    logic [SQ_W-1:0]         r_sq;
    logic [RATIO_W-1:0]      r_ratio;
    t_side                   r_side;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] rounded;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     adv;

    // Round to nearest, halves away from zero: bias 2^15 up, 2^15-1 when negative
    always_comb begin
        prod    = PROD_W'(i_acc) * $signed({1'b0, i_sq});
        biased  = prod + (prod[PROD_W-1] ? PROD_W'(32767) : PROD_W'(32768));
        rounded = biased >>> 16;
        n_acc   = rounded[ACC_W-1:0] + i_coef;
    end

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_acc   <= n_acc;
            r_sq    <= i_sq;
            r_ratio <= i_ratio;
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_sq    = r_sq;
    assign o_ratio = r_ratio;
    assign o_side  = r_side;

endmodule

`default_nettype wire
